// ===== src/lstm_cell_pointwise_forward_top_macros.svh =====
// Assertion macros shared by the checker file of this block.
`ifndef LSTM_CELL_POINTWISE_FORWARD_TOP_MACROS_SVH
`define LSTM_CELL_POINTWISE_FORWARD_TOP_MACROS_SVH

// Whenever the condition holds, the consequence must follow.
`define LCPF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lcpf checker: implication violated");

// The expression must hold at every clock edge out of reset.
`define LCPF_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("lcpf checker: invariant violated");

`endif

// ===== src/lcpf_pkg.sv =====
package lcpf_pkg;

	// Fixed-point formats of the datapath.
	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 12;
	localparam int ACT_W      = FRAC_BITS + 1;
	localparam int GATE_W     = ACT_W + 1;
	localparam int HID_W      = FRAC_BITS + 2;
	localparam int TAB_DEPTH  = 2 ** (DATA_WIDTH - 1) + 1;
	localparam int ONE        = 2 ** FRAC_BITS;
	localparam int HALF       = 2 ** (FRAC_BITS - 1);
	localparam real ONE_R     = 2.0 ** FRAC_BITS;
	localparam real STEP_R    = 1.0 / ONE_R;

	localparam logic signed [DATA_WIDTH-1:0] CELL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] CELL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	typedef enum logic {
		ACT_SIGMOID,
		ACT_TANH
	} act_kind_t;

	// Cell result handed from the cell path to the hidden path.
	typedef struct packed {
		logic                         valid;
		logic signed [DATA_WIDTH-1:0] cell_val;
		logic [ACT_W-1:0]             out_gate;
	} cell_stage_t;

	// Activation of a non-negative argument, rounded to nearest at one LSB.
	function automatic logic [ACT_W-1:0] act_value(act_kind_t kind, int mag);
		real x;
		real v;
		x = real'(mag) * STEP_R;
		case (kind)
			ACT_SIGMOID: v = 0.5 + 0.5 * $tanh(0.5 * x);
			default:     v = $tanh(x);
		endcase
		return ACT_W'($rtoi($floor(v * ONE_R + 0.5)));
	endfunction

	// Magnitude of a signed word; the most negative value maps to its own pattern.
	function automatic logic [DATA_WIDTH-1:0] magnitude(logic signed [DATA_WIDTH-1:0] x);
		return x[DATA_WIDTH-1] ? DATA_WIDTH'(-x) : DATA_WIDTH'(x);
	endfunction

endpackage

// ===== src/lstm_cell_pointwise_forward_top.sv =====
// Pointwise LSTM cell update, one element per request.
// Each request passes stages 1 to 3 in the cell path and 4 to 6 in the hidden path before done.
// Throughput: one request every cycle; busy stays low, the six-stage pipeline never stalls.
// The rate is set by the single registered read port of each activation table.
// Reset clears the valid bits only; the done strobe is low until a request has passed.
module lstm_cell_pointwise_forward_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic                                   first_step,
	input  logic signed [lcpf_pkg::DATA_WIDTH-1:0] pre_input_gate,
	input  logic signed [lcpf_pkg::DATA_WIDTH-1:0] pre_forget_gate,
	input  logic signed [lcpf_pkg::DATA_WIDTH-1:0] pre_output_gate,
	input  logic signed [lcpf_pkg::DATA_WIDTH-1:0] pre_candidate,
	input  logic signed [lcpf_pkg::DATA_WIDTH-1:0] prev_cell,
	output logic                                   done,
	output logic signed [lcpf_pkg::DATA_WIDTH-1:0] cell_out,
	output logic signed [lcpf_pkg::HID_W-1:0]      hidden_out
);
	import lcpf_pkg::*;

	cell_stage_t cell_res;
	logic        accept;

	// The pipeline takes a request in every cycle.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	lcpf_cell_path u_cell_path (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (accept),
		.first_step      (first_step),
		.pre_input_gate  (pre_input_gate),
		.pre_forget_gate (pre_forget_gate),
		.pre_output_gate (pre_output_gate),
		.pre_candidate   (pre_candidate),
		.prev_cell       (prev_cell),
		.cell_res        (cell_res)
	);

	lcpf_hidden_path u_hidden_path (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_res   (cell_res),
		.done       (done),
		.cell_out   (cell_out),
		.hidden_out (hidden_out)
	);

endmodule

// ===== src/lcpf_act_rom.sv =====
module lcpf_act_rom #(
	parameter lcpf_pkg::act_kind_t KIND = lcpf_pkg::ACT_SIGMOID
) (
	input  logic                            clk,
	input  logic [lcpf_pkg::DATA_WIDTH-1:0] addr,
	output logic [lcpf_pkg::ACT_W-1:0]      data
);
	import lcpf_pkg::*;

	logic [ACT_W-1:0] tab [TAB_DEPTH];

	// Table over every argument magnitude, filled once at start-up.
	initial begin
		for (int i = 0; i < TAB_DEPTH; i++) begin
			tab[i] = act_value(KIND, i);
		end
	end

	// Registered read of the activation table.
	always_ff @(posedge clk) begin
		data <= tab[addr];
	end

endmodule

// ===== src/lcpf_cell_path.sv =====
module lcpf_cell_path (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic                                   first_step,
	input  logic signed [lcpf_pkg::DATA_WIDTH-1:0] pre_input_gate,
	input  logic signed [lcpf_pkg::DATA_WIDTH-1:0] pre_forget_gate,
	input  logic signed [lcpf_pkg::DATA_WIDTH-1:0] pre_output_gate,
	input  logic signed [lcpf_pkg::DATA_WIDTH-1:0] pre_candidate,
	input  logic signed [lcpf_pkg::DATA_WIDTH-1:0] prev_cell,
	output lcpf_pkg::cell_stage_t                  cell_res
);
	import lcpf_pkg::*;

	localparam int PROD_CI_W = 2 * GATE_W;
	localparam int PROD_FP_W = GATE_W + DATA_WIDTH;
	localparam int SUM_W     = PROD_FP_W - FRAC_BITS + 1;

	// Stage 1: table reads and the signs that fold them back.
	logic [ACT_W-1:0] ti_s1, tf_s1, to_s1, tc_s1;
	logic valid_s1, first_s1;
	logic sg_i_s1, sg_f_s1, sg_o_s1, sg_c_s1;
	logic signed [DATA_WIDTH-1:0] prev_s1;

	lcpf_act_rom #(.KIND(ACT_SIGMOID)) u_rom_in (
		.clk(clk), .addr(magnitude(pre_input_gate)), .data(ti_s1));
	lcpf_act_rom #(.KIND(ACT_SIGMOID)) u_rom_forget (
		.clk(clk), .addr(magnitude(pre_forget_gate)), .data(tf_s1));
	lcpf_act_rom #(.KIND(ACT_SIGMOID)) u_rom_out (
		.clk(clk), .addr(magnitude(pre_output_gate)), .data(to_s1));
	lcpf_act_rom #(.KIND(ACT_TANH)) u_rom_cand (
		.clk(clk), .addr(magnitude(pre_candidate)), .data(tc_s1));

	always_ff @(posedge clk) begin
		first_s1 <= first_step;
		sg_i_s1  <= pre_input_gate[DATA_WIDTH-1];
		sg_f_s1  <= pre_forget_gate[DATA_WIDTH-1];
		sg_o_s1  <= pre_output_gate[DATA_WIDTH-1];
		sg_c_s1  <= pre_candidate[DATA_WIDTH-1];
		prev_s1  <= prev_cell;
	end

	// Stage 2: fold the tables by symmetry and form both products.
	logic [ACT_W-1:0] gi, gf, go;
	logic signed [GATE_W-1:0] gc;
	logic signed [PROD_CI_W-1:0] prod_ci;
	logic signed [PROD_FP_W-1:0] prod_fp;

	always_comb begin
		gi = sg_i_s1 ? ACT_W'(ONE) - ti_s1 : ti_s1;
		gf = sg_f_s1 ? ACT_W'(ONE) - tf_s1 : tf_s1;
		go = sg_o_s1 ? ACT_W'(ONE) - to_s1 : to_s1;
		gc = sg_c_s1 ? -$signed({1'b0, tc_s1}) : $signed({1'b0, tc_s1});
		prod_ci = gc * $signed({1'b0, gi});
		prod_fp = $signed({1'b0, gf}) * prev_s1;
	end

	logic valid_s2, first_s2;
	logic [ACT_W-1:0] go_s2;
	logic signed [PROD_CI_W-1:0] prod_ci_s2;
	logic signed [PROD_FP_W-1:0] prod_fp_s2;

	always_ff @(posedge clk) begin
		first_s2   <= first_s1;
		go_s2      <= go;
		prod_ci_s2 <= prod_ci;
		prod_fp_s2 <= prod_fp;
	end

	// Stage 3: round each product, add and saturate the cell.
	logic signed [PROD_CI_W-1:0] ci_biased;
	logic signed [PROD_FP_W-1:0] fp_biased;
	logic signed [PROD_CI_W-FRAC_BITS-1:0] ci_r;
	logic signed [PROD_FP_W-FRAC_BITS-1:0] fp_r;
	logic signed [SUM_W-1:0] cell_sum;
	logic signed [DATA_WIDTH-1:0] cell_sat;

	always_comb begin
		ci_biased = prod_ci_s2 + $signed(PROD_CI_W'(HALF));
		fp_biased = prod_fp_s2 + $signed(PROD_FP_W'(HALF));
		ci_r = $signed(ci_biased[PROD_CI_W-1:FRAC_BITS]);
		fp_r = $signed(fp_biased[PROD_FP_W-1:FRAC_BITS]);
		cell_sum = SUM_W'(ci_r) + (first_s2 ? SUM_W'(0) : SUM_W'(fp_r));
		if (cell_sum > SUM_W'(CELL_MAX)) begin
			cell_sat = CELL_MAX;
		end else if (cell_sum < SUM_W'(CELL_MIN)) begin
			cell_sat = CELL_MIN;
		end else begin
			cell_sat = DATA_WIDTH'(cell_sum);
		end
	end

	logic valid_s3;
	logic signed [DATA_WIDTH-1:0] cell_s3;
	logic [ACT_W-1:0] go_s3;

	always_ff @(posedge clk) begin
		cell_s3 <= cell_sat;
		go_s3   <= go_s2;
	end

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign cell_res.valid    = valid_s3;
	assign cell_res.cell_val = cell_s3;
	assign cell_res.out_gate = go_s3;

endmodule

// ===== src/lcpf_hidden_path.sv =====
module lcpf_hidden_path (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  lcpf_pkg::cell_stage_t                  cell_res,
	output logic                                   done,
	output logic signed [lcpf_pkg::DATA_WIDTH-1:0] cell_out,
	output logic signed [lcpf_pkg::HID_W-1:0]      hidden_out
);
	import lcpf_pkg::*;

	localparam int PROD_H_W = 2 * GATE_W;

	// Stage 4: tanh of the cell through the table.
	logic [ACT_W-1:0] tt_s4;
	logic valid_s4, sign_s4;
	logic [ACT_W-1:0] go_s4;
	logic signed [DATA_WIDTH-1:0] cell_s4;

	lcpf_act_rom #(.KIND(ACT_TANH)) u_rom_cell (
		.clk(clk), .addr(magnitude(cell_res.cell_val)), .data(tt_s4));

	always_ff @(posedge clk) begin
		sign_s4 <= cell_res.cell_val[DATA_WIDTH-1];
		go_s4   <= cell_res.out_gate;
		cell_s4 <= cell_res.cell_val;
	end

	// Stage 5: signed tanh times the output gate.
	logic signed [GATE_W-1:0] th;
	logic signed [PROD_H_W-1:0] prod_h;

	always_comb begin
		th = sign_s4 ? -$signed({1'b0, tt_s4}) : $signed({1'b0, tt_s4});
		prod_h = th * $signed({1'b0, go_s4});
	end

	logic valid_s5;
	logic signed [PROD_H_W-1:0] prod_h_s5;
	logic signed [DATA_WIDTH-1:0] cell_s5;

	always_ff @(posedge clk) begin
		prod_h_s5 <= prod_h;
		cell_s5   <= cell_s4;
	end

	// Stage 6: round the hidden value into the output register.
	logic signed [PROD_H_W-1:0] h_biased;
	logic signed [HID_W-1:0] hid_r;

	always_comb begin
		h_biased = prod_h_s5 + $signed(PROD_H_W'(HALF));
		hid_r = $signed(h_biased[FRAC_BITS+HID_W-1:FRAC_BITS]);
	end

	logic valid_s6;
	logic signed [DATA_WIDTH-1:0] cell_s6;
	logic signed [HID_W-1:0] hid_s6;

	always_ff @(posedge clk) begin
		cell_s6 <= cell_s5;
		hid_s6  <= hid_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s4 <= cell_res.valid;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	assign done       = valid_s6;
	assign cell_out   = cell_s6;
	assign hidden_out = hid_s6;

endmodule

// ===== src/lcpf_checker.sv =====
`include "lstm_cell_pointwise_forward_top_macros.svh"

module lcpf_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   start,
	input logic                                   busy,
	input logic                                   done,
	input logic signed [lcpf_pkg::DATA_WIDTH-1:0] cell_out,
	input logic signed [lcpf_pkg::HID_W-1:0]      hidden_out
);
	import lcpf_pkg::*;

	// Every accepted request is followed by its result strobe.
	`LCPF_ASSERT_IMPLIES(a_result_follows, clk, arst_n, start && !busy, ##6 done)

	// No result strobe without an accepted request ahead of it in the pipeline.
	`LCPF_ASSERT_IMPLIES(a_no_spurious, clk, arst_n, done, $past(start && !busy, 6))

	// The hidden value lies within plus and minus one.
	`LCPF_ASSERT_IMPLIES(a_hidden_range, clk, arst_n, done,
		hidden_out <= 14'sd4096 && hidden_out >= -14'sd4096)

	// A zero cell gives a zero hidden value whatever the output gate.
	`LCPF_ASSERT_IMPLIES(a_zero_cell, clk, arst_n, done && cell_out == '0, hidden_out == '0)

endmodule

bind lstm_cell_pointwise_forward_top lcpf_checker u_lcpf_checker (.*);

// ===== bench/tb_lstm_cell_pointwise_forward_top.sv =====
`timescale 1ns / 100ps

module tb_lstm_cell_pointwise_forward_top;

	localparam int DW    = lcpf_pkg::DATA_WIDTH;
	localparam int FRAC  = lcpf_pkg::FRAC_BITS;
	localparam int HW    = lcpf_pkg::HID_W;
	localparam int RAND_ITEMS     = 850;
	localparam int WATCHDOG_LIMIT = 500;
	localparam int DRAIN_CYCLES   = 20;

	// Exact activation arithmetic works with 56 fraction bits.
	localparam int          QF       = 56;
	localparam logic [63:0] UNIT     = 64'd1 << QF;
	localparam logic [63:0] LN2_FIX  = 64'h00B17217F7D1CF7A;
	localparam int          EXP_STOP = 40;

	localparam logic signed [DW-1:0] W_MAX = lcpf_pkg::CELL_MAX;
	localparam logic signed [DW-1:0] W_MIN = lcpf_pkg::CELL_MIN;
	localparam logic signed [HW-1:0] H_ONE_LSB_BELOW = HW'(lcpf_pkg::ONE - 1);

	typedef struct {
		logic                 first;
		logic signed [DW-1:0] pre_in;
		logic signed [DW-1:0] pre_forget;
		logic signed [DW-1:0] pre_out;
		logic signed [DW-1:0] pre_cand;
		logic signed [DW-1:0] prev;
	} lstm_req_t;

	typedef struct {
		logic signed [DW-1:0] cell_val;
		logic signed [HW-1:0] hidden;
	} lstm_res_t;

	typedef struct {
		lstm_req_t req;
		bit        typed;
		lstm_res_t res;
	} stim_row_t;

	logic                 clk             = 1'b0;
	logic                 arst_n          = 1'b0;
	logic                 start           = 1'b0;
	logic                 first_step      = 1'b0;
	logic signed [DW-1:0] pre_input_gate  = '0;
	logic signed [DW-1:0] pre_forget_gate = '0;
	logic signed [DW-1:0] pre_output_gate = '0;
	logic signed [DW-1:0] pre_candidate   = '0;
	logic signed [DW-1:0] prev_cell       = '0;
	logic                 busy;
	logic                 done;
	logic signed [DW-1:0] cell_out;
	logic signed [HW-1:0] hidden_out;

	lstm_res_t expected_cell_q [$];
	stim_row_t stim_rows [$];
	int        fail_count   = 0;
	int        stall_cycles = 0;

	lstm_cell_pointwise_forward_top u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.first_step      (first_step),
		.pre_input_gate  (pre_input_gate),
		.pre_forget_gate (pre_forget_gate),
		.pre_output_gate (pre_output_gate),
		.pre_candidate   (pre_candidate),
		.prev_cell       (prev_cell),
		.done            (done),
		.cell_out        (cell_out),
		.hidden_out      (hidden_out)
	);

	always #5 clk = ~clk;

	// exp(-mag * 2^-FRAC) with 56 fraction bits, by range reduction and a series.
	function automatic logic [63:0] exp_neg_fix(logic [63:0] mag);
		logic [63:0]  y;
		logic [63:0]  n;
		logic [63:0]  r;
		logic [63:0]  acc;
		logic [63:0]  term;
		logic [127:0] prod;
		int           k;
		if ((mag >> FRAC) >= 64'(EXP_STOP)) return 64'd0;
		y = mag << (QF - FRAC);
		n = y / LN2_FIX;
		r = y - n * LN2_FIX;
		acc = UNIT;
		term = UNIT;
		for (k = 1; k <= 24; k++) begin
			prod = {64'd0, term} * {64'd0, r};
			term = 64'(prod >> QF) / 64'(k);
			if (k % 2 == 1) acc = acc - term;
			else acc = acc + term;
		end
		if (n >= 64'd63) return 64'd0;
		return acc >> n;
	endfunction

	// Quotient num/den scaled by 2^FRAC, rounded to nearest.
	function automatic longint ratio_round(logic [63:0] num, logic [63:0] den);
		logic [63:0] q;
		logic [63:0] r;
		int          i;
		q = num / den;
		r = num % den;
		for (i = 0; i < FRAC + 1; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 64'd1;
			end
		end
		return longint'((q + 64'd1) >> 1);
	endfunction

	function automatic logic [63:0] abs_q(longint x);
		return (x < 0) ? 64'(-x) : 64'(x);
	endfunction

	function automatic longint sigmoid_q(longint x);
		logic [63:0] e;
		e = exp_neg_fix(abs_q(x));
		if (x >= 0) return ratio_round(UNIT, UNIT + e);
		return ratio_round(e, UNIT + e);
	endfunction

	function automatic longint tanh_q(longint x);
		logic [63:0] e2;
		longint      v;
		e2 = exp_neg_fix(2 * abs_q(x));
		v = ratio_round(UNIT - e2, UNIT + e2);
		return (x < 0) ? -v : v;
	endfunction

	// Product with 2*FRAC fraction bits back to FRAC, ties towards plus infinity.
	function automatic longint round_q(longint p);
		return (p + (longint'(1) << (FRAC - 1))) >>> FRAC;
	endfunction

	// New cell and hidden value of one element.
	function automatic lstm_res_t lstm_cell_predict(lstm_req_t req);
		longint    gi;
		longint    gf;
		longint    go;
		longint    gc;
		longint    cell_new;
		longint    hid;
		longint    cmax;
		lstm_res_t res;
		gi = sigmoid_q(longint'(req.pre_in));
		gf = sigmoid_q(longint'(req.pre_forget));
		go = sigmoid_q(longint'(req.pre_out));
		gc = tanh_q(longint'(req.pre_cand));
		cmax = (longint'(1) << (DW - 1)) - 1;
		cell_new = round_q(gc * gi);
		if (!req.first) cell_new = cell_new + round_q(gf * longint'(req.prev));
		if (cell_new > cmax) cell_new = cmax;
		if (cell_new < -cmax - 1) cell_new = -cmax - 1;
		hid = round_q(tanh_q(cell_new) * go);
		res.cell_val = cell_new[DW-1:0];
		res.hidden = hid[HW-1:0];
		return res;
	endfunction

	task automatic add_row(logic first, logic signed [DW-1:0] gi, logic signed [DW-1:0] gf,
			logic signed [DW-1:0] go, logic signed [DW-1:0] gc, logic signed [DW-1:0] prev,
			bit typed, logic signed [DW-1:0] ecell, logic signed [HW-1:0] ehid);
		stim_row_t row;
		row.req.first = first;
		row.req.pre_in = gi;
		row.req.pre_forget = gf;
		row.req.pre_out = go;
		row.req.pre_cand = gc;
		row.req.prev = prev;
		row.typed = typed;
		row.res.cell_val = ecell;
		row.res.hidden = ehid;
		stim_rows.insert(stim_rows.size(), row);
	endtask

	// Presents one request after an idle gap and waits until it is taken.
	task automatic issue_request(lstm_req_t req, int gap, bit typed, lstm_res_t typed_res);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		first_step <= req.first;
		pre_input_gate <= req.pre_in;
		pre_forget_gate <= req.pre_forget;
		pre_output_gate <= req.pre_out;
		pre_candidate <= req.pre_cand;
		prev_cell <= req.prev;
		do @(posedge clk); while (busy);
		expected_cell_q.insert(expected_cell_q.size(),
			typed ? typed_res : lstm_cell_predict(req));
	endtask

	// Random word: mostly the sensitive range of the activations, sometimes anything, sometimes near the extremes.
	function automatic logic signed [DW-1:0] rand_word(int mode);
		case (mode)
			0: return DW'($urandom);
			1: return DW'(int'($urandom_range(24576)) - 12288);
			default: return $urandom_range(1) ? DW'(W_MAX - DW'($urandom_range(2047)))
				: DW'(W_MIN + DW'($urandom_range(2047)));
		endcase
	endfunction

	function automatic int pick_gap(bit bursty);
		int sel;
		sel = $urandom_range(99);
		if (bursty || sel < 60) return 0;
		if (sel < 90) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// Stimulus: directed rows first, then random requests, then drain.
	initial begin
		lstm_req_t req;
		lstm_res_t none;
		int        drain;
		int        sel;
		bit        bursty;
		none.cell_val = '0;
		none.hidden = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero candidate leaves the cell at zero on the first step or with a zero previous cell.
		add_row(1'b1, '0, '0, '0, '0, '0, 1'b1, '0, '0);
		add_row(1'b0, '0, '0, '0, '0, '0, 1'b1, '0, '0);
		add_row(1'b1, W_MAX, W_MAX, W_MAX, '0, W_MAX, 1'b1, '0, '0);
		add_row(1'b1, W_MIN, W_MIN, W_MIN, '0, W_MIN, 1'b1, '0, '0);
		// Cell overflow in both directions.
		add_row(1'b0, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, 1'b1, W_MAX, H_ONE_LSB_BELOW);
		add_row(1'b0, W_MAX, W_MAX, W_MAX, W_MIN, W_MIN, 1'b1, W_MIN, -H_ONE_LSB_BELOW);
		add_row(1'b1, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, 1'b0, '0, '0);
		add_row(1'b1, W_MIN, '0, W_MAX, W_MAX, '0, 1'b0, '0, '0);
		add_row(1'b1, W_MAX, '0, W_MIN, W_MIN, '0, 1'b0, '0, '0);
		add_row(1'b1, W_MAX, '0, W_MIN, W_MAX, '0, 1'b0, '0, '0);
		add_row(1'b0, '0, W_MIN, W_MAX, '0, W_MAX, 1'b0, '0, '0);
		add_row(1'b0, '0, W_MAX, W_MAX, '0, W_MIN, 1'b0, '0, '0);
		add_row(1'b0, '0, '0, '0, '0, W_MAX, 1'b0, '0, '0);
		add_row(1'b0, 16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd1, 1'b0, '0, '0);
		add_row(1'b0, 16'sd4096, -16'sd4096, 16'sd4096, -16'sd4096, 16'sd4096, 1'b0, '0, '0);
		add_row(1'b1, -16'sd8192, '0, 16'sd8192, 16'sd16384, '0, 1'b0, '0, '0);
		add_row(1'b0, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b0, '0, '0);
		add_row(1'b0, 16'sh5555, 16'sh5555, 16'sh5555, 16'sh5555, 16'sh5555, 1'b0, '0, '0);
		add_row(1'b0, 16'shAAAA, 16'shAAAA, 16'shAAAA, 16'shAAAA, 16'shAAAA, 1'b0, '0, '0);
		add_row(1'b0, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 1'b0, '0, '0);
		add_row(1'b0, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, 1'b0, '0, '0);

		foreach (stim_rows[i]) begin
			issue_request(stim_rows[i].req, pick_gap(1'b0), stim_rows[i].typed,
				stim_rows[i].res);
		end

		// Random requests, in segments of 50 that are each either a burst or gapped, chosen at random.
		bursty = 1'b0;
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 50 == 0) bursty = $urandom_range(2) == 0;
			sel = $urandom_range(99);
			sel = (sel < 70) ? 1 : (sel < 90) ? 0 : 2;
			req.first = $urandom_range(3) == 0;
			req.pre_in = rand_word(sel);
			req.pre_forget = rand_word(sel);
			req.pre_out = rand_word(sel);
			req.pre_cand = rand_word(sel);
			req.prev = rand_word($urandom_range(2));
			issue_request(req, pick_gap(bursty), 1'b0, none);
		end
		start <= 1'b0;

		// Wait for every outstanding result, then a little longer for strays.
		while (expected_cell_q.size() != 0) @(posedge clk);
		for (drain = 0; drain < DRAIN_CYCLES; drain++) @(posedge clk);
		if (expected_cell_q.size() != 0) begin
			$error("results missing: %0d still expected", expected_cell_q.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Result checker: each strobe is compared with the oldest expected result.
	always @(posedge clk) begin
		lstm_res_t want;
		if (arst_n && done) begin
			if (expected_cell_q.size() == 0) begin
				$error("unexpected result: cell_out %0d hidden_out %0d", cell_out, hidden_out);
				fail_count++;
			end else begin
				want = expected_cell_q.pop_front();
				if (cell_out !== want.cell_val) begin
					$error("cell_out mismatch: expected %0d actual %0d",
						want.cell_val, cell_out);
					fail_count++;
				end
				if (hidden_out !== want.hidden) begin
					$error("hidden_out mismatch: expected %0d actual %0d",
						want.hidden, hidden_out);
					fail_count++;
				end
			end
		end
	end

	// Watchdog over cycles in which neither a request nor a result moves.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

endmodule
